>>> design/ir_remote_frame_receiver_top_assert.svh
// ---------------------------------------------------------------------------
// IR frame receiver assertion macros
// Shared property templates for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef IR_REMOTE_FRAME_RECEIVER_TOP_ASSERT_SVH
`define IR_REMOTE_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IRFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/irfr_pkg.sv
// ---------------------------------------------------------------------------
// IR frame receiver package
// Types and fixed constants shared by the receiver modules.
// ---------------------------------------------------------------------------
package irfr_pkg;

    localparam int COMMAND_BITS = 7;
    localparam int VOTE_FRAMES  = 3;
    localparam int TICK_W       = 16;
    localparam int ADDR_BITS    = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int SLOT_W       = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_TICKS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TICKS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_DEBOUNCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_DEBOUNCE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_ADDRESS    = 3'd5;

    // Reset values of the configuration registers
    localparam logic [TICK_W-1:0]    RST_START_TICKS    = 16'd20000;
    localparam logic [TICK_W-1:0]    RST_SYNC_TICKS     = 16'd9600;
    localparam logic [TICK_W-1:0]    RST_READ_TICKS     = 16'd7200;
    localparam logic [TICK_W-1:0]    RST_EDGE_DEBOUNCE  = 16'd400;
    localparam logic [TICK_W-1:0]    RST_SCAN_DEBOUNCE  = 16'd400;
    localparam logic [ADDR_BITS-1:0] RST_EXP_ADDRESS    = 5'd1;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_START = 3'd1,
        MODE_SYNC  = 3'd2,
        MODE_READ  = 3'd3,
        MODE_ERROR = 3'd4
    } irfr_mode_t;

    // Frame outcome handed from the frame sequencer to the vote stage
    typedef struct packed {
        logic                    valid;
        logic                    ok;
        logic [COMMAND_BITS-1:0] cmd;
    } irfr_frame_res_t;

    // Full result of one transaction on the output side
    typedef struct packed {
        logic [COMMAND_BITS-1:0] vote_cmd;
        logic                    vote_ok;
        logic                    vote_done;
        logic [COMMAND_BITS-1:0] frame_cmd;
        logic                    frame_ok;
    } irfr_result_t;

endpackage

>>> design/irfr_edge.sv
// ---------------------------------------------------------------------------
// IR falling-edge qualifier
// Confirms a falling edge after high was seen and low held for the debounce.
// ---------------------------------------------------------------------------
module irfr_edge
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       pin,
    input  logic                       idle,
    input  logic                       clear,
    input  logic [irfr_pkg::TICK_W-1:0] edge_debounce,
    input  logic [irfr_pkg::TICK_W-1:0] scan_debounce,
    output logic                       edge_hit
);
    import irfr_pkg::*;

    localparam int CNT_W = TICK_W + 1;

    logic             saw_high_reg, saw_high_next;
    logic [CNT_W-1:0] low_cnt_reg, low_cnt_next;
    logic [CNT_W-1:0] thr;

    // The first edge of a frame needs the extra scan debounce on top
    assign thr = CNT_W'(edge_debounce) + (idle ? CNT_W'(scan_debounce) : '0);

    always_comb
    begin
        edge_hit      = 1'b0;
        saw_high_next = saw_high_reg;
        low_cnt_next  = low_cnt_reg;
        if (pin)
        begin
            saw_high_next = 1'b1;
            low_cnt_next  = '0;
        end
        else if (saw_high_reg)
        begin
            if (low_cnt_reg >= thr)
            begin
                edge_hit      = 1'b1;
                saw_high_next = 1'b0;
                low_cnt_next  = '0;
            end
            else
            begin
                low_cnt_next = low_cnt_reg + 1'b1;
            end
        end
        if (clear)
        begin
            saw_high_next = 1'b0;
            low_cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saw_high_reg <= 1'b0;
            low_cnt_reg  <= '0;
        end
        else if (adv)
        begin
            saw_high_reg <= saw_high_next;
            low_cnt_reg  <= low_cnt_next;
        end
    end

endmodule

>>> design/irfr_frame.sv
// ---------------------------------------------------------------------------
// IR frame sequencer
// Start/sync/read phases, phase timer and bit assembly of one frame.
// ---------------------------------------------------------------------------
module irfr_frame
#(
    parameter int FRAME_BITS = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          pin,
    input  logic                          edge_hit,
    input  logic [irfr_pkg::TICK_W-1:0]    start_ticks,
    input  logic [irfr_pkg::TICK_W-1:0]    scan_debounce,
    input  logic [irfr_pkg::TICK_W-1:0]    sync_ticks,
    input  logic [irfr_pkg::TICK_W-1:0]    read_ticks,
    input  logic [irfr_pkg::ADDR_BITS-1:0] expected_address,
    output logic                          mode_idle,
    output irfr_pkg::irfr_frame_res_t     frame_res
);
    import irfr_pkg::*;

    localparam int IDX_W = $clog2(FRAME_BITS);

    irfr_mode_t            mode_reg, mode_next;
    logic [TICK_W-1:0]     timer_reg, timer_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;

    logic                  expired;
    logic [TICK_W-1:0]     timer_dec;
    logic                  bit_in;
    logic [FRAME_BITS-1:0] word;
    logic                  last_bit;
    logic [TICK_W-1:0]     addr_ext;
    logic                  addr_match;

    // A window of N ticks runs out on the N-th later tick; zero acts as one
    assign expired   = (timer_reg <= TICK_W'(1));
    assign timer_dec = expired ? '0 : timer_reg - 1'b1;

    // Carrier seen (pin low) reads as a one
    assign bit_in     = ~pin;
    assign word       = shift_reg | (FRAME_BITS'(bit_in) << idx_reg);
    assign last_bit   = (idx_reg == IDX_W'(FRAME_BITS - 1));
    assign addr_ext   = TICK_W'(word[FRAME_BITS-1:COMMAND_BITS]);
    assign addr_match = (addr_ext == TICK_W'(expected_address));
    assign mode_idle  = (mode_reg == MODE_IDLE);

    // Next state
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (edge_hit)
                    mode_next = MODE_START;
            end
            MODE_START:
            begin
                if (edge_hit)
                    mode_next = MODE_ERROR;
                else if (expired)
                    mode_next = MODE_SYNC;
            end
            MODE_SYNC:
            begin
                if (edge_hit)
                    mode_next = MODE_READ;
                else if (expired)
                    mode_next = MODE_ERROR;
            end
            MODE_READ:
            begin
                if (edge_hit)
                    mode_next = MODE_ERROR;
                else if (expired)
                    mode_next = last_bit ? MODE_IDLE : MODE_SYNC;
            end
            MODE_ERROR:
            begin
                mode_next = MODE_IDLE;
            end
            default:
            begin
                mode_next = MODE_ERROR;
            end
        endcase
    end

    // Timer, bit assembly and frame outcome
    always_comb
    begin
        timer_next = timer_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        frame_res  = '0;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (edge_hit)
                    timer_next = (start_ticks > scan_debounce) ?
                                 start_ticks - scan_debounce : '0;
            end
            MODE_START:
            begin
                if (!edge_hit)
                    timer_next = expired ? sync_ticks : timer_dec;
            end
            MODE_SYNC:
            begin
                timer_next = edge_hit ? read_ticks : timer_dec;
            end
            MODE_READ:
            begin
                if (!edge_hit && expired)
                begin
                    if (last_bit)
                    begin
                        frame_res.valid = 1'b1;
                        frame_res.ok    = addr_match;
                        frame_res.cmd   = addr_match ? word[COMMAND_BITS-1:0] : '0;
                    end
                    else
                    begin
                        timer_next = sync_ticks;
                        idx_next   = idx_reg + 1'b1;
                        shift_next = word;
                    end
                end
                else if (!edge_hit)
                begin
                    timer_next = timer_dec;
                end
            end
            MODE_ERROR:
            begin
                frame_res.valid = 1'b1;
            end
            default:
            begin
                timer_next = timer_reg;
            end
        endcase
        // Every finished frame returns the receiver to a clean idle
        if (frame_res.valid)
        begin
            timer_next = '0;
            idx_next   = '0;
            shift_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            timer_reg <= '0;
            idx_reg   <= '0;
            shift_reg <= '0;
        end
        else if (adv)
        begin
            mode_reg  <= mode_next;
            timer_reg <= timer_next;
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
        end
    end

endmodule

>>> design/irfr_vote.sv
// ---------------------------------------------------------------------------
// IR frame vote
// Keeps the last group of frame outcomes and forms the two-of-three vote.
// ---------------------------------------------------------------------------
module irfr_vote
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  irfr_pkg::irfr_frame_res_t frame_res,
    output irfr_pkg::irfr_result_t    result
);
    import irfr_pkg::*;

    localparam int ENTRY_W = COMMAND_BITS + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VOTE_FRAMES - 1);

    logic [ENTRY_W-1:0] results_reg [VOTE_FRAMES];
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [ENTRY_W-1:0] entry_new;
    logic [ENTRY_W-1:0] winner;
    logic               agree;
    logic               done;

    assign entry_new = {frame_res.ok, frame_res.cmd};
    assign done      = (slot_reg == LAST_SLOT);
    assign slot_next = done ? '0 : slot_reg + 1'b1;

    // The third entry of the group is the frame closing it right now
    always_comb
    begin
        agree  = 1'b1;
        winner = '0;
        priority if (results_reg[0] == results_reg[1])
            winner = results_reg[0];
        else if (results_reg[1] == entry_new)
            winner = results_reg[1];
        else if (entry_new == results_reg[0])
            winner = results_reg[0];
        else
            agree = 1'b0;
    end

    always_comb
    begin
        result           = '0;
        result.frame_ok  = frame_res.ok;
        result.frame_cmd = frame_res.cmd;
        result.vote_done = done;
        if (done && agree && winner[ENTRY_W-1])
        begin
            result.vote_ok  = 1'b1;
            result.vote_cmd = winner[COMMAND_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && frame_res.valid)
            results_reg[slot_reg] <= entry_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else if (adv && frame_res.valid)
            slot_reg <= slot_next;
    end

endmodule

>>> design/irfr_outbuf.sv
// ---------------------------------------------------------------------------
// IR result output buffer
// Output register with one skid entry in front of the result stream.
// ---------------------------------------------------------------------------
module irfr_outbuf
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  irfr_pkg::irfr_result_t push_data,
    output logic                   full,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [15:0]            m_axis_tdata,  // frame_ok, frame_command, vote_ok, vote_command
    output logic                   m_axis_tlast   // vote_done
);
    import irfr_pkg::*;

    logic         main_valid_reg;
    logic         skid_valid_reg;
    irfr_result_t main_reg;
    irfr_result_t skid_reg;
    logic         pop;

    assign pop  = main_valid_reg && m_axis_tready;
    assign full = skid_valid_reg;

    assign m_axis_tvalid = main_valid_reg;
    assign m_axis_tlast  = main_reg.vote_done;
    assign m_axis_tdata  = {main_reg.vote_cmd, main_reg.vote_ok,
                            main_reg.frame_cmd, main_reg.frame_ok};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        else if (push)
            skid_reg <= push_data;
    end

endmodule

>>> design/ir_remote_frame_receiver_top.sv
// ---------------------------------------------------------------------------
// IR remote frame receiver, top level
// SIRC-style 12-bit frame decoder with a two-of-three vote over three frames.
// ---------------------------------------------------------------------------
//  channel   | direction | payload
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | tdata[0] pin_level, one pin sample per transaction
//  m_axis    | out       | tdata frame_ok, frame_command, vote_ok,
//            |           | vote_command; tlast vote_done
//  cfg       | in        | cfg_we / cfg_index / cfg_data register writes
//
// One sample per cycle while the skid entry is free: a sample is held in
// the input register, the debounce/sequencer/vote logic updates from it
// and, when a frame ends, writes the result register.
// A stalled result goes to the skid entry; the input side stops only when
// both the result register and the skid entry hold results.
// rst_n clears the control state and loads the register defaults.
// ---------------------------------------------------------------------------
module ir_remote_frame_receiver_top
#(
    parameter int FRAME_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] pin_level
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] frame_ok, [7:1] frame_command,
                                        // [8] vote_ok, [15:9] vote_command
    output logic        m_axis_tlast,   // vote_done
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import irfr_pkg::*;

    // Configuration registers
    logic [TICK_W-1:0]    start_ticks_reg;
    logic [TICK_W-1:0]    sync_ticks_reg;
    logic [TICK_W-1:0]    read_ticks_reg;
    logic [TICK_W-1:0]    edge_deb_reg;
    logic [TICK_W-1:0]    scan_deb_reg;
    logic [ADDR_BITS-1:0] exp_addr_reg;

    // Input register
    logic s1_valid_reg;
    logic s1_pin_reg;

    logic            adv;
    logic            full;
    logic            edge_hit;
    logic            mode_idle;
    irfr_frame_res_t frame_res;
    irfr_result_t    result;

    // The core steps whenever a sample is held and the skid entry is free
    assign adv           = s1_valid_reg && !full;
    assign s_axis_tready = !s1_valid_reg || !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            s1_pin_reg <= s_axis_tdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_ticks_reg <= RST_START_TICKS;
            sync_ticks_reg  <= RST_SYNC_TICKS;
            read_ticks_reg  <= RST_READ_TICKS;
            edge_deb_reg    <= RST_EDGE_DEBOUNCE;
            scan_deb_reg    <= RST_SCAN_DEBOUNCE;
            exp_addr_reg    <= RST_EXP_ADDRESS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_TICKS:   start_ticks_reg <= cfg_data;
                CFG_SYNC_TICKS:    sync_ticks_reg  <= cfg_data;
                CFG_READ_TICKS:    read_ticks_reg  <= cfg_data;
                CFG_EDGE_DEBOUNCE: edge_deb_reg    <= cfg_data;
                CFG_SCAN_DEBOUNCE: scan_deb_reg    <= cfg_data;
                CFG_EXP_ADDRESS:   exp_addr_reg    <= cfg_data[ADDR_BITS-1:0];
                default:           exp_addr_reg    <= exp_addr_reg;
            endcase
        end
    end

    // Debounced falling edges; a finished frame clears the qualifier
    irfr_edge u_edge
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .pin           (s1_pin_reg),
        .idle          (mode_idle),
        .clear         (frame_res.valid),
        .edge_debounce (edge_deb_reg),
        .scan_debounce (scan_deb_reg),
        .edge_hit      (edge_hit)
    );

    irfr_frame #(
        .FRAME_BITS (FRAME_BITS)
    ) u_frame
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (adv),
        .pin              (s1_pin_reg),
        .edge_hit         (edge_hit),
        .start_ticks      (start_ticks_reg),
        .scan_debounce    (scan_deb_reg),
        .sync_ticks       (sync_ticks_reg),
        .read_ticks       (read_ticks_reg),
        .expected_address (exp_addr_reg),
        .mode_idle        (mode_idle),
        .frame_res        (frame_res)
    );

    irfr_vote u_vote
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .frame_res (frame_res),
        .result    (result)
    );

    irfr_outbuf u_outbuf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (adv && frame_res.valid),
        .push_data     (result),
        .full          (full),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> design/irfr_checker.sv
// ---------------------------------------------------------------------------
// IR frame receiver port checker
// Port-level properties of the receiver, bound to the top level.
// ---------------------------------------------------------------------------
`include "ir_remote_frame_receiver_top_assert.svh"

module irfr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A held result keeps its payload until taken
    `IRFR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // A failed frame reports a zero command
    `IRFR_ASSERT_NOW(a_fail_cmd_zero, clk, rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[7:1] == 7'd0, "failed frame with nonzero command")

    // Vote fields stay clear on results that do not close a group
    `IRFR_ASSERT_NOW(a_vote_only_last, clk, rst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[15:8] == 8'd0, "vote fields set outside a group end")

    // Input back-pressure only comes from results waiting downstream
    `IRFR_ASSERT_NOW(a_stall_cause, clk, rst_n, !s_axis_tready, m_axis_tvalid && !$past(m_axis_tready), "input stalled without pending results")

endmodule

bind ir_remote_frame_receiver_top irfr_checker u_irfr_checker (.*);
